// ----- hdl/hsvr_pkg.sv -----
// shared widths, limits and hue sector codes for the hsv to rgb core
package hsvr_pkg;

  localparam int PIX_W  = 16;
  localparam int CHAN_W = 8;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // color wheel sector that a scaled hue falls in
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

endpackage

// ----- hdl/hsvr_if.sv -----
// valid/ready channel interfaces for hsv input items and rgb result items
interface hsvr_hsv_if;
  import hsvr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] hue;
  logic [PIX_W-1:0] saturation;
  logic [PIX_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvr_rgb_if;
  import hsvr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/hsvr_to8.sv -----
// scales a q.2*frac channel product by 255, rounds half up and saturates to 8 bits
module hsvr_to8 #(
  parameter int FRAC_BITS = 15
) (
  input  logic [2*FRAC_BITS+1:0]   prod,
  output logic [hsvr_pkg::CHAN_W-1:0] chan
);
  import hsvr_pkg::*;

  localparam int PW = 2 * FRAC_BITS + 2;
  localparam int SW = PW + 8;
  localparam int RW = SW - 2 * FRAC_BITS;
  localparam logic [SW-1:0] OUT_HALF = SW'(1) << (2 * FRAC_BITS - 1);

  logic [SW-1:0] scaled;
  logic [RW-1:0] rounded;

  // 255 * c as (c << 8) - c
  assign scaled  = {prod, 8'b0} - {8'b0, prod} + OUT_HALF;
  assign rounded = scaled[SW-1:2*FRAC_BITS];
  assign chan    = (rounded > RW'(CHAN_MAX)) ? CHAN_MAX : rounded[CHAN_W-1:0];

endmodule

// ----- hdl/hsv_to_rgb_pixel_core.sv -----
// hsv to rgb pixel converter: five-stage pipeline, one pixel per clock when out_ch does not stall
//
// Use: in_ch carries hue, saturation and brightness as unsigned fractions
// with FRAC_BITS fraction bits (1 << FRAC_BITS is 1.0, larger values act as
// 1.0, a full-turn hue wraps to red). out_ch carries 8-bit red, green, blue.
// An item moves on a channel at a clock edge with valid and ready both high.
// Throughput: one pixel per cycle while out_ch does not stall, set by the
// five register stages (clamp and hue scale, s*f products, rounding and
// sector routing, v*factor products, scale by 255 and round), each holding
// one multiply rank at most. An accepted pixel passes through them in order
// and shows on out_ch from the last one until it is taken.
// Stalls: each stage advances when it is empty or the next one advances, so
// while out_ch is stalled the core still takes pixels into empty stages and
// drops in_ch.ready only once every stage is full. Nothing is lost or sent
// twice.
// Reset: rst_n low at a clock edge empties the pipeline; no other state.
module hsv_to_rgb_pixel_core #(
  parameter int FRAC_BITS = 15
) (
  input logic        clk,
  input logic        rst_n,
  hsvr_hsv_if.sink   in_ch,
  hsvr_rgb_if.source out_ch
);
  import hsvr_pkg::*;

  localparam int NSTG = 5;
  localparam int VW   = FRAC_BITS + 1;
  localparam int XW   = (VW > PIX_W) ? VW : PIX_W;
  localparam int PW   = 2 * VW;

  localparam logic [VW-1:0]   ONE_V   = VW'(1) << FRAC_BITS;
  localparam logic [XW-1:0]   ONE_X   = XW'(1) << FRAC_BITS;
  localparam logic [VW+1:0]   SIX_ONE = (VW + 2)'(6) << FRAC_BITS;
  localparam logic [PW:0]     HALF_P  = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [VW+1:0]   ONE_R   = (VW + 2)'(1) << FRAC_BITS;

  function automatic logic [VW-1:0] clamp_one(input logic [PIX_W-1:0] x);
    logic [XW-1:0] xw;
    xw = XW'(x);
    return (xw > ONE_X) ? ONE_V : xw[VW-1:0];
  endfunction

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // per-stage advance: a stage moves when empty or when its successor moves
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: clamp, hue times six, sector and fraction
  logic [VW-1:0]        hc, sc, vc;
  logic [VW+1:0]        h6, h6w;
  sector_t              sec1_r;
  logic [FRAC_BITS-1:0] f1_r;
  logic [VW-1:0]        s1_r, v1_r;

  assign hc  = clamp_one(in_ch.hue);
  assign sc  = clamp_one(in_ch.saturation);
  assign vc  = clamp_one(in_ch.brightness);
  assign h6  = {hc, 2'b00} + {1'b0, hc, 1'b0};
  // a full turn wraps back to the red sector
  assign h6w = (h6 >= SIX_ONE) ? '0 : h6;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec1_r <= sector_t'(h6w[VW+1:FRAC_BITS]);
      f1_r   <= h6w[FRAC_BITS-1:0];
      s1_r   <= sc;
      v1_r   <= vc;
    end
  end

  // stage 2: s*f and s*(1-f)
  logic [VW-1:0] omf;
  logic [PW-1:0] psf, psg;
  logic [PW-1:0] psf2_r, psg2_r;
  logic [VW-1:0] s2_r, v2_r;
  sector_t       sec2_r;

  assign omf = ONE_V - {1'b0, f1_r};
  assign psf = PW'(s1_r) * PW'({1'b0, f1_r});
  assign psg = PW'(s1_r) * PW'(omf);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      psf2_r <= psf;
      psg2_r <= psg;
      s2_r   <= s1_r;
      v2_r   <= v1_r;
      sec2_r <= sec1_r;
    end
  end

  // stage 3: round products, form factors, route by sector
  logic [PW:0]   sf_sum, sg_sum;
  logic [VW+1:0] sf_rnd, sg_rnd;
  logic [VW-1:0] sf_c, sg_c, fp, fq, ft;
  logic [VW-1:0] rf, gf, bf;
  logic [VW-1:0] rf3_r, gf3_r, bf3_r, v3_r;

  assign sf_sum = {1'b0, psf2_r} + HALF_P;
  assign sg_sum = {1'b0, psg2_r} + HALF_P;
  assign sf_rnd = sf_sum[PW:FRAC_BITS];
  assign sg_rnd = sg_sum[PW:FRAC_BITS];
  assign sf_c   = (sf_rnd > ONE_R) ? ONE_V : sf_rnd[VW-1:0];
  assign sg_c   = (sg_rnd > ONE_R) ? ONE_V : sg_rnd[VW-1:0];
  assign fp     = ONE_V - s2_r;
  assign fq     = ONE_V - sf_c;
  assign ft     = ONE_V - sg_c;

  always_comb begin
    unique case (sec2_r)
      SEC_R_TO_Y: begin rf = ONE_V; gf = ft;    bf = fp;    end
      SEC_Y_TO_G: begin rf = fq;    gf = ONE_V; bf = fp;    end
      SEC_G_TO_C: begin rf = fp;    gf = ONE_V; bf = ft;    end
      SEC_C_TO_B: begin rf = fp;    gf = fq;    bf = ONE_V; end
      SEC_B_TO_M: begin rf = ft;    gf = fp;    bf = ONE_V; end
      default:    begin rf = ONE_V; gf = fp;    bf = fq;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      rf3_r <= rf;
      gf3_r <= gf;
      bf3_r <= bf;
      v3_r  <= v2_r;
    end
  end

  // stage 4: brightness times each factor
  logic [PW-1:0] cr4_r, cg4_r, cb4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      cr4_r <= PW'(v3_r) * PW'(rf3_r);
      cg4_r <= PW'(v3_r) * PW'(gf3_r);
      cb4_r <= PW'(v3_r) * PW'(bf3_r);
    end
  end

  // stage 5: scale to 8 bits into the output register
  logic [CHAN_W-1:0] r8, g8, b8;
  logic [CHAN_W-1:0] r5_r, g5_r, b5_r;

  hsvr_to8 #(.FRAC_BITS(FRAC_BITS)) u_to8_r (.prod(cr4_r), .chan(r8));
  hsvr_to8 #(.FRAC_BITS(FRAC_BITS)) u_to8_g (.prod(cg4_r), .chan(g8));
  hsvr_to8 #(.FRAC_BITS(FRAC_BITS)) u_to8_b (.prod(cb4_r), .chan(b8));

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      r5_r <= r8;
      g5_r <= g8;
      b5_r <= b8;
    end
  end

  assign out_ch.valid = v_r[NSTG-1];
  assign out_ch.red   = r5_r;
  assign out_ch.green = g5_r;
  assign out_ch.blue  = b5_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted item did not reach the first stage");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (rf3_r <= ONE_V && gf3_r <= ONE_V && bf3_r <= ONE_V))
    else $error("channel factor above one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !adv[2]) |=> (v_r[1] && $stable(psf2_r) && $stable(psg2_r)))
    else $error("stalled product stage changed");

  a_out_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ch.ready) |-> (&v_r && !out_ch.ready))
    else $error("input stalled while the pipeline had room");

endmodule
